// ----- rtl/msgs_pkg.sv -----
package msgs_pkg;

    localparam int COORD_BITS = 32;
    localparam int ACC_W = 48;
    localparam int MAG_W = ACC_W - 1;
    localparam int COEF_W = 24;
    localparam int PROD_W = MAG_W + COEF_W;
    localparam int FRAC_BITS = 16;
    localparam int DIM_W = 5;
    localparam int XW = 17;
    localparam int LANES = 3;
    localparam int SLOTS = 6;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [LANES*COORD_BITS-1:0] vec_t;
    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic [PROD_W-1:0] prod_t;
    typedef logic [DIM_W-1:0] dim_t;
    typedef logic [XW-1:0] xidx_t;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_TICK = 2'd1,
        MODE_READ = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_WIDTH   = 3'd0,
        REG_HEIGHT  = 3'd1,
        REG_DEPTH   = 3'd2,
        REG_SPRING  = 3'd3,
        REG_DAMPING = 3'd4,
        REG_ANCHOR  = 3'd5
    } reg_idx_t;

    localparam acc_t CMAX = {{(ACC_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam acc_t CMIN = {{(ACC_W-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};
    localparam acc_t PUSH_ROW = 48'sd327680;
    localparam acc_t PUSH_CENTER = 48'sd655360;

    function automatic logic clip_hit(acc_t v);
        return (v > CMAX) || (v < CMIN);
    endfunction

    function automatic coord_t clip_coord(acc_t v);
        coord_t r;
        if (v > CMAX)
        begin
            r = CMAX[COORD_BITS-1:0];
        end
        else if (v < CMIN)
        begin
            r = CMIN[COORD_BITS-1:0];
        end
        else
        begin
            r = v[COORD_BITS-1:0];
        end
        return r;
    endfunction

    function automatic coord_t lane(vec_t v, int unsigned c);
        return v[c*COORD_BITS +: COORD_BITS];
    endfunction

    function automatic logic is_anchor(dim_t i, dim_t j, dim_t k, dim_t w, dim_t h, dim_t d,
                                       logic [1:0] ad);
        logic [1:0] cnt;
        cnt = 2'((i == '0) || (i == dim_t'(w - 1'b1)))
            + 2'((j == '0) || (j == dim_t'(h - 1'b1)))
            + 2'((k == '0) || (k == dim_t'(d - 1'b1)));
        return (3'(cnt) + 3'(ad)) > 3'd3;
    endfunction

endpackage

// ----- rtl/mass_spring_grid_step_unit.sv -----
// Mass-spring lattice stepper with node storage in two on-chip memories.
// Input channel (in_valid/in_stall): one transaction carries a mode and its
// operands. Mode 0 loads a node position and clears its velocity, mode 1 runs
// one simulation tick over the whole lattice, mode 2 reads a node back.
// Output channel (out_valid/out_stall): every input transaction yields exactly
// one result transaction, held stable while out_stall is high.
// Configuration is a write port (cfg_write, cfg_index, cfg_data); the user must
// write it only while the block is idle, as the block itself does not enforce it.
// A read recovers the node coordinates by stepping down one plane and then one
// row at a time. A tick walks all nodes in order: an anchored node is skipped;
// a free node is read, then each present face neighbor is read and multiplied,
// then damping, velocity and position are updated, all through the single read
// port of the memories and the shared multiply lanes. One transaction is in work at a time.
// After reset the velocity memory is cleared, one entry per cycle, over all
// MAX_NODES entries; in_stall stays high during that pass.
// When the receiver stalls, a finished result waits in the output register.
// The block may take and work on the next transaction meanwhile, but holds
// it in its completion state until the waiting result has been delivered.
module mass_spring_grid_step_unit #(
    parameter int MAX_NODES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [11:0] node_index,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [15:0] time_step,
    input  logic        push_bottom_row,
    input  logic        push_center,
    input  logic        push_back_face,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] node_x,
    output logic signed [31:0] node_y,
    output logic signed [31:0] node_z,
    output logic        node_anchored,
    output logic        saturated,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import msgs_pkg::*;

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DONE, S_RDK, S_RDJ, S_TSTART, S_NODE, S_OWN,
        S_NBSEL, S_NBMUL, S_NBACC, S_DMUL, S_DACC, S_VMUL, S_VACC, S_PMUL, S_PACC
    } state_t;

    state_t state_reg;

    vec_t pos_mem [MAX_NODES];
    vec_t vel_mem [MAX_NODES];
    vec_t pos_rd_reg;
    vec_t vel_rd_reg;

    dim_t w_reg, h_reg, d_reg;
    logic [COEF_W-1:0] spring_reg, damp_reg;
    logic [1:0] ad_reg;

    mode_t mode_reg;
    logic idx_ok_reg;
    logic rd_ok_reg;
    logic [15:0] dt_reg;
    logic kb_reg, kc_reg, kf_reg;

    xidx_t cur_reg;
    xidx_t rem_reg;
    dim_t ci_reg, cj_reg, ck_reg;
    logic [2:0] slot_reg;
    coord_t own_p_reg [LANES];
    coord_t own_v_reg [LANES];
    acc_t f_reg [LANES];
    prod_t prod_reg [LANES];
    logic neg_reg [LANES];
    logic sat_reg;
    logic anch_reg;
    logic [AW-1:0] clr_reg;

    logic out_valid_reg;
    coord_t out_x_reg, out_y_reg, out_z_reg;
    logic out_anch_reg, out_sat_reg;

    logic in_acc;
    xidx_t plane_x, n_x, w_x, mid_x, in_idx_x;
    logic grid_ok;
    logic cur_anchor;
    logic nb_present;
    xidx_t nb_addr;
    acc_t push_val;

    logic rd_en;
    logic [AW-1:0] rd_addr;
    logic pos_we, vel_we;
    logic [AW-1:0] waddr;
    vec_t pos_wdata, vel_wdata;

    acc_t mul_a [LANES];
    logic [COEF_W-1:0] mul_b;
    acc_t mag [LANES];
    acc_t term [LANES];
    acc_t sum_v [LANES];
    acc_t sum_p [LANES];
    coord_t new_v [LANES];
    coord_t new_p [LANES];
    logic hit_v, hit_p;

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc = in_valid && !in_stall;

    assign w_x = xidx_t'(w_reg);
    assign plane_x = w_x * xidx_t'(h_reg);
    assign n_x = plane_x * xidx_t'(d_reg);
    assign grid_ok = (n_x != '0) && (n_x <= xidx_t'(MAX_NODES));
    assign mid_x = (w_x >> 1) + (plane_x >> 1);
    assign in_idx_x = xidx_t'(node_index);

    assign cur_anchor = is_anchor(ci_reg, cj_reg, ck_reg, w_reg, h_reg, d_reg, ad_reg);

    always_comb
    begin
        nb_present = 1'b0;
        nb_addr = cur_reg;
        case (slot_reg)
            3'd0:
            begin
                nb_present = (ci_reg != '0);
                nb_addr = cur_reg - 1'b1;
            end
            3'd1:
            begin
                nb_present = (6'(ci_reg) + 6'd1) < 6'(w_reg);
                nb_addr = cur_reg + 1'b1;
            end
            3'd2:
            begin
                nb_present = (cj_reg != '0);
                nb_addr = cur_reg - w_x;
            end
            3'd3:
            begin
                nb_present = (6'(cj_reg) + 6'd1) < 6'(h_reg);
                nb_addr = cur_reg + w_x;
            end
            3'd4:
            begin
                nb_present = (ck_reg != '0);
                nb_addr = cur_reg - plane_x;
            end
            3'd5:
            begin
                nb_present = (6'(ck_reg) + 6'd1) < 6'(d_reg);
                nb_addr = cur_reg + plane_x;
            end
            default:
            begin
                nb_present = 1'b0;
                nb_addr = cur_reg;
            end
        endcase
    end

    always_comb
    begin
        push_val = '0;
        if (kb_reg && (cur_reg > w_x) && (cur_reg < (w_x << 1)))
        begin
            push_val = push_val + PUSH_ROW;
        end
        if (kc_reg && ((cur_reg == mid_x) || (cur_reg + 1'b1 == mid_x)
                       || (cur_reg == mid_x + 1'b1) || (cur_reg + w_x == mid_x)
                       || (cur_reg == mid_x + w_x)))
        begin
            push_val = push_val + PUSH_CENTER;
        end
        if (kf_reg && (cur_reg < plane_x))
        begin
            push_val = push_val - PUSH_CENTER;
        end
    end

    always_comb
    begin
        mul_b = spring_reg;
        for (int c = 0; c < LANES; c++)
        begin
            mul_a[c] = acc_t'(lane(pos_rd_reg, c)) - acc_t'(own_p_reg[c]);
        end
        case (state_reg)
            S_DMUL:
            begin
                mul_b = damp_reg;
                for (int c = 0; c < LANES; c++)
                begin
                    mul_a[c] = acc_t'(own_v_reg[c]);
                end
            end
            S_VMUL:
            begin
                mul_b = COEF_W'(dt_reg);
                for (int c = 0; c < LANES; c++)
                begin
                    mul_a[c] = f_reg[c];
                end
            end
            S_PMUL:
            begin
                mul_b = COEF_W'(dt_reg);
                for (int c = 0; c < LANES; c++)
                begin
                    mul_a[c] = acc_t'(own_v_reg[c]);
                end
            end
            default:
            begin
                mul_b = spring_reg;
            end
        endcase
        hit_v = 1'b0;
        hit_p = 1'b0;
        for (int c = 0; c < LANES; c++)
        begin
            mag[c] = (mul_a[c] < 0) ? -mul_a[c] : mul_a[c];
            term[c] = $signed({1'b0, prod_reg[c][FRAC_BITS +: MAG_W]});
            if (neg_reg[c])
            begin
                term[c] = -term[c];
            end
            sum_v[c] = acc_t'(own_v_reg[c]) + term[c];
            sum_p[c] = acc_t'(own_p_reg[c]) + term[c];
            new_v[c] = clip_coord(sum_v[c]);
            new_p[c] = clip_coord(sum_p[c]);
            hit_v = hit_v | clip_hit(sum_v[c]);
            hit_p = hit_p | clip_hit(sum_p[c]);
        end
    end

    always_comb
    begin
        rd_en = 1'b0;
        rd_addr = cur_reg[AW-1:0];
        pos_we = 1'b0;
        vel_we = 1'b0;
        waddr = cur_reg[AW-1:0];
        pos_wdata = {new_p[2], new_p[1], new_p[0]};
        vel_wdata = {own_v_reg[2], own_v_reg[1], own_v_reg[0]};
        unique case (state_reg)
            S_CLEAR:
            begin
                vel_we = 1'b1;
                waddr = clr_reg;
                vel_wdata = '0;
            end
            S_IDLE:
            begin
                if (in_acc && (in_idx_x < xidx_t'(MAX_NODES)))
                begin
                    waddr = in_idx_x[AW-1:0];
                    rd_addr = in_idx_x[AW-1:0];
                    if (mode == MODE_LOAD)
                    begin
                        pos_we = 1'b1;
                        vel_we = 1'b1;
                        pos_wdata = {pos_z, pos_y, pos_x};
                        vel_wdata = '0;
                    end
                    else if (mode == MODE_READ)
                    begin
                        rd_en = 1'b1;
                    end
                end
            end
            S_NODE:
            begin
                rd_en = (cur_reg != n_x) && !cur_anchor;
            end
            S_NBSEL:
            begin
                rd_en = (slot_reg < 3'(SLOTS)) && nb_present;
                rd_addr = nb_addr[AW-1:0];
            end
            S_PACC:
            begin
                pos_we = 1'b1;
                vel_we = 1'b1;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[waddr] <= pos_wdata;
        end
        if (rd_en)
        begin
            pos_rd_reg <= pos_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (vel_we)
        begin
            vel_mem[waddr] <= vel_wdata;
        end
        if (rd_en)
        begin
            vel_rd_reg <= vel_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_NBMUL || state_reg == S_DMUL || state_reg == S_VMUL
            || state_reg == S_PMUL)
        begin
            for (int c = 0; c < LANES; c++)
            begin
                prod_reg[c] <= PROD_W'(mag[c][MAG_W-1:0]) * PROD_W'(mul_b);
                neg_reg[c] <= mul_a[c][ACC_W-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= 5'd16;
            h_reg <= 5'd16;
            d_reg <= 5'd1;
            spring_reg <= 24'd65536;
            damp_reg <= '0;
            ad_reg <= 2'd1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_WIDTH:   w_reg <= cfg_data[DIM_W-1:0];
                REG_HEIGHT:  h_reg <= cfg_data[DIM_W-1:0];
                REG_DEPTH:   d_reg <= cfg_data[DIM_W-1:0];
                REG_SPRING:  spring_reg <= cfg_data;
                REG_DAMPING: damp_reg <= cfg_data;
                REG_ANCHOR:  ad_reg <= cfg_data[1:0];
                default:     ad_reg <= ad_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            out_valid_reg <= 1'b0;
            mode_reg <= MODE_NONE;
            idx_ok_reg <= 1'b0;
            rd_ok_reg <= 1'b0;
            dt_reg <= '0;
            kb_reg <= 1'b0;
            kc_reg <= 1'b0;
            kf_reg <= 1'b0;
            cur_reg <= '0;
            rem_reg <= '0;
            ci_reg <= '0;
            cj_reg <= '0;
            ck_reg <= '0;
            slot_reg <= '0;
            sat_reg <= 1'b0;
            anch_reg <= 1'b0;
            out_x_reg <= '0;
            out_y_reg <= '0;
            out_z_reg <= '0;
            out_anch_reg <= 1'b0;
            out_sat_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(MAX_NODES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        mode_reg <= mode_t'(mode);
                        idx_ok_reg <= (in_idx_x < xidx_t'(MAX_NODES));
                        rd_ok_reg <= grid_ok && (in_idx_x < n_x);
                        dt_reg <= time_step;
                        kb_reg <= push_bottom_row;
                        kc_reg <= push_center;
                        kf_reg <= push_back_face;
                        rem_reg <= in_idx_x;
                        ci_reg <= '0;
                        cj_reg <= '0;
                        ck_reg <= '0;
                        case (mode_t'(mode))
                            MODE_TICK: state_reg <= S_TSTART;
                            MODE_READ: state_reg <= S_RDK;
                            default:   state_reg <= S_DONE;
                        endcase
                    end
                end
                S_RDK:
                begin
                    if (!rd_ok_reg)
                    begin
                        anch_reg <= 1'b0;
                        state_reg <= S_DONE;
                    end
                    else if (rem_reg >= plane_x)
                    begin
                        rem_reg <= rem_reg - plane_x;
                        ck_reg <= ck_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_RDJ;
                    end
                end
                S_RDJ:
                begin
                    if (rem_reg >= w_x)
                    begin
                        rem_reg <= rem_reg - w_x;
                        cj_reg <= cj_reg + 1'b1;
                    end
                    else
                    begin
                        anch_reg <= is_anchor(rem_reg[DIM_W-1:0], cj_reg, ck_reg,
                                              w_reg, h_reg, d_reg, ad_reg);
                        state_reg <= S_DONE;
                    end
                end
                S_TSTART:
                begin
                    sat_reg <= 1'b0;
                    cur_reg <= '0;
                    state_reg <= grid_ok ? S_NODE : S_DONE;
                end
                S_NODE:
                begin
                    if (cur_reg == n_x)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (cur_anchor)
                    begin
                        cur_reg <= cur_reg + 1'b1;
                        if (ci_reg == dim_t'(w_reg - 1'b1))
                        begin
                            ci_reg <= '0;
                            if (cj_reg == dim_t'(h_reg - 1'b1))
                            begin
                                cj_reg <= '0;
                                ck_reg <= ck_reg + 1'b1;
                            end
                            else
                            begin
                                cj_reg <= cj_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            ci_reg <= ci_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        state_reg <= S_OWN;
                    end
                end
                S_OWN:
                begin
                    for (int c = 0; c < LANES; c++)
                    begin
                        own_p_reg[c] <= lane(pos_rd_reg, c);
                        own_v_reg[c] <= lane(vel_rd_reg, c);
                        f_reg[c] <= '0;
                    end
                    slot_reg <= '0;
                    state_reg <= S_NBSEL;
                end
                S_NBSEL:
                begin
                    if (slot_reg >= 3'(SLOTS))
                    begin
                        state_reg <= S_DMUL;
                    end
                    else if (nb_present)
                    begin
                        state_reg <= S_NBMUL;
                    end
                    else
                    begin
                        slot_reg <= slot_reg + 1'b1;
                    end
                end
                S_NBMUL:
                begin
                    state_reg <= S_NBACC;
                end
                S_NBACC:
                begin
                    for (int c = 0; c < LANES; c++)
                    begin
                        f_reg[c] <= f_reg[c] + term[c];
                    end
                    slot_reg <= slot_reg + 1'b1;
                    state_reg <= S_NBSEL;
                end
                S_DMUL:
                begin
                    state_reg <= S_DACC;
                end
                S_DACC:
                begin
                    f_reg[0] <= f_reg[0] - term[0];
                    f_reg[1] <= f_reg[1] - term[1];
                    f_reg[2] <= f_reg[2] - term[2] + push_val;
                    state_reg <= S_VMUL;
                end
                S_VMUL:
                begin
                    state_reg <= S_VACC;
                end
                S_VACC:
                begin
                    for (int c = 0; c < LANES; c++)
                    begin
                        own_v_reg[c] <= new_v[c];
                    end
                    sat_reg <= sat_reg | hit_v;
                    state_reg <= S_PMUL;
                end
                S_PMUL:
                begin
                    state_reg <= S_PACC;
                end
                S_PACC:
                begin
                    sat_reg <= sat_reg | hit_p;
                    cur_reg <= cur_reg + 1'b1;
                    if (ci_reg == dim_t'(w_reg - 1'b1))
                    begin
                        ci_reg <= '0;
                        if (cj_reg == dim_t'(h_reg - 1'b1))
                        begin
                            cj_reg <= '0;
                            ck_reg <= ck_reg + 1'b1;
                        end
                        else
                        begin
                            cj_reg <= cj_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        ci_reg <= ci_reg + 1'b1;
                    end
                    state_reg <= S_NODE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        if (mode_reg == MODE_READ && idx_ok_reg)
                        begin
                            out_x_reg <= lane(pos_rd_reg, 0);
                            out_y_reg <= lane(pos_rd_reg, 1);
                            out_z_reg <= lane(pos_rd_reg, 2);
                            out_anch_reg <= anch_reg;
                        end
                        else
                        begin
                            out_x_reg <= '0;
                            out_y_reg <= '0;
                            out_z_reg <= '0;
                            out_anch_reg <= 1'b0;
                        end
                        out_sat_reg <= (mode_reg == MODE_TICK) && sat_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign node_x = out_x_reg;
    assign node_y = out_y_reg;
    assign node_z = out_z_reg;
    assign node_anchored = out_anch_reg;
    assign saturated = out_sat_reg;

    assert property (@(posedge clk) disable iff (!rst_n) !(pos_we && rd_en))
        else $error("Position write and read issued in the same cycle.");

    assert property (@(posedge clk) disable iff (!rst_n) (state_reg == S_CLEAR) |-> in_stall)
        else $error("Input accepted during the velocity clearing pass.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NODE && cur_reg != n_x) |->
            (ci_reg < w_reg && cj_reg < h_reg && ck_reg < d_reg))
        else $error("Lattice coordinate counters out of range.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("Result raised outside the completion state.");

endmodule
